// File: src/bsa_pkg.sv
// Shared types and constants for the buddy split allocator.
package bsa_pkg;

  localparam int ORDER_W    = 5;
  localparam int ID_W       = 16;
  localparam int SIZE_W     = 31;
  localparam int COUNT_W    = 7;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam logic [ORDER_W-1:0] RESET_ORDER = 5'd6;

  typedef enum logic [1:0] {
    STAT_ALLOC = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_ENTRY = 2'd3
  } alloc_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ORDER,
    S_SCAN,
    S_SPLIT,
    S_REPLY,
    S_QUERY
  } fsm_state_t;

  // Controls fanned out from the sequencer to the cell row.
  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctl_t;

endpackage

// File: src/buddy_split_allocator_top.sv
// Buddy split allocator: top level with the rotating block list and its sequencer.
//
// Usage:
//   s_* carries requests. s_tuser = 0 allocates (owner, request_size in s_tdata),
//   s_tuser = 1 lists all blocks. m_* returns results; m_tuser is the status,
//   m_tlast marks the final transfer of a request. cfg_* writes total_order and
//   rebuilds the list as one free block of that order.
// Operation:
//   The list sits in a ring of MAX_BLOCKS cells that rotates one entry per cycle while
//   a pass runs, except while a query waits on the receiver; every pass over the list
//   leaves the ring aligned. Allocate: the order is computed, then one scan pass, one
//   pass per split, then the result is posted. Query: one pass, one transfer per
//   listed block. One request is worked on at a time.
// Reset:
//   rst (synchronous) restores total_order 6 and a single free block; no clearing
//   pass is needed, entries beyond the block count are never read.
// Stalls:
//   Results go through an output register. During a query the ring pauses while
//   the receiver holds m_tready low; a pending allocate result does not block the
//   next request from being taken.
module buddy_split_allocator_top
  import bsa_pkg::*;
#(
  parameter int MAX_BLOCKS = 64,
  parameter int OWNER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // owner[15:0], request_size[46:16], zero[47]
  input  logic                  s_tuser,   // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // block_count[6:0], entry_owner[22:7], zero[23]
  output logic [1:0]            m_tuser,   // status
  output logic                  m_tlast,   // last
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ORDER_W-1:0]    cfg_data   // total_order
);

  localparam int EW = OWNER_BITS + ORDER_W;

  chain_ctl_t         ctl;
  logic [EW-1:0]      tail;
  logic [EW-1:0]      load_entry;
  logic [EW-1:0]      cell_q [MAX_BLOCKS];
  alloc_status_t      out_status;
  logic [COUNT_W-1:0] out_count;
  logic [ID_W-1:0]    out_owner;

  bsa_seq #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .OWNER_BITS (OWNER_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_func    (s_tuser),
    .in_owner   (s_tdata[15:0]),
    .in_size    (s_tdata[46:16]),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_order  (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_count  (out_count),
    .out_owner  (out_owner),
    .out_last   (m_tlast),
    .ctl        (ctl),
    .head       (cell_q[0]),
    .tail       (tail),
    .load_entry (load_entry)
  );

  // Cell 0 is the head seen by the sequencer; the sequencer writes the
  // (possibly modified) head back into the far end of the row.
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    if (i == MAX_BLOCKS - 1) begin : g_end
      bsa_cell #(.W(EW)) u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .load  ((i == 0) ? ctl.load : 1'b0),
        .d     (tail),
        .ld    (load_entry),
        .q     (cell_q[i])
      );
    end else begin : g_mid
      bsa_cell #(.W(EW)) u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .load  ((i == 0) ? ctl.load : 1'b0),
        .d     (cell_q[i+1]),
        .ld    (load_entry),
        .q     (cell_q[i])
      );
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {1'b0, out_owner, out_count};

endmodule

// File: src/bsa_cell.sv
// One list entry of the rotating block list: owner and order.
module bsa_cell
  import bsa_pkg::*;
#(
  parameter int W = 21
) (
  input  logic         clk,
  input  logic         shift,
  input  logic         load,
  input  logic [W-1:0] d,
  input  logic [W-1:0] ld,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= ld;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// File: src/bsa_seq.sv
// Sequencer: order computation, scan and split passes, query walk, result register.
module bsa_seq
  import bsa_pkg::*;
#(
  parameter int MAX_BLOCKS = 64,
  parameter int OWNER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [ID_W-1:0]                 in_owner,
  input  logic [SIZE_W-1:0]               in_size,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ORDER_W-1:0]              cfg_order,
  output logic                            out_valid,
  input  logic                            out_ready,
  output alloc_status_t                   out_status,
  output logic [COUNT_W-1:0]              out_count,
  output logic [ID_W-1:0]                 out_owner,
  output logic                            out_last,
  output chain_ctl_t                      ctl,
  input  logic [OWNER_BITS+ORDER_W-1:0]   head,
  output logic [OWNER_BITS+ORDER_W-1:0]   tail,
  output logic [OWNER_BITS+ORDER_W-1:0]   load_entry
);

  localparam int EW = OWNER_BITS + ORDER_W;
  localparam int PW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int TW = $clog2(MAX_BLOCKS + 1);

  fsm_state_t state, state_next;

  logic [PW-1:0]         pos;
  logic [TW-1:0]         total;
  logic [ORDER_W-1:0]    k;
  logic [31:0]           pw;
  logic [SIZE_W-1:0]     size;
  logic [OWNER_BITS-1:0] who;
  logic [PW-1:0]         big_pos;
  logic [ORDER_W-1:0]    big_order;
  logic                  found_exact;
  logic                  found_big;
  logic [EW-1:0]         carry;
  logic                  carrying;
  alloc_status_t         res_status;

  logic [OWNER_BITS-1:0] h_owner;
  logic [ORDER_W-1:0]    h_order;
  logic [TW-1:0]         pos_ext;
  logic                  live;
  logic                  pass_end;
  logic                  h_free;
  logic                  hit_exact;
  logic                  hit_big;
  logic                  at_big;
  logic [ORDER_W-1:0]    split_order;
  logic                  split_final;
  logic                  adv;
  logic                  load_out;
  logic                  order_more;
  logic                  exact_any;
  logic                  big_any;
  logic                  list_full;
  logic                  full_after;
  logic                  in_xfer;
  logic                  cfg_xfer;

  assign h_owner     = head[EW-1:ORDER_W];
  assign h_order     = head[ORDER_W-1:0];
  assign pos_ext     = TW'(pos);
  assign live        = pos_ext < total;
  assign pass_end    = pos == PW'(MAX_BLOCKS - 1);
  assign h_free      = h_owner == '0;
  assign hit_exact   = live && h_free && (h_order == k) && !found_exact;
  assign hit_big     = live && h_free && (h_order > k) && !found_big;
  assign at_big      = pos == big_pos;
  assign split_order = big_order - 1'b1;
  assign split_final = split_order == k;
  assign adv         = !out_valid || out_ready;
  assign order_more  = pw < 32'(size);
  assign exact_any   = found_exact || hit_exact;
  assign big_any     = found_big || hit_big;
  assign list_full   = total == TW'(MAX_BLOCKS);
  assign full_after  = total == TW'(MAX_BLOCKS - 1);
  assign in_xfer     = in_valid && in_ready;
  assign cfg_xfer    = cfg_valid && cfg_ready;
  assign load_out    = adv && ((state == S_REPLY) || ((state == S_QUERY) && live));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = in_func ? S_QUERY : S_ORDER;
        end
      end
      S_ORDER: begin
        if (!order_more) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pass_end) begin
          if (exact_any || !big_any || list_full) begin
            state_next = S_REPLY;
          end else begin
            state_next = S_SPLIT;
          end
        end
      end
      S_SPLIT: begin
        if (pass_end && (split_final || full_after)) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (adv) begin
          state_next = S_IDLE;
        end
      end
      S_QUERY: begin
        if (adv && pass_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs toward ports and the cell row
  always_comb begin
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    ctl.shift  = 1'b0;
    tail       = head;
    unique case (state)
      S_IDLE: begin
        in_ready  = !cfg_valid;
        cfg_ready = 1'b1;
      end
      S_SCAN: begin
        ctl.shift = 1'b1;
        if (hit_exact) begin
          tail = {who, k};
        end
      end
      S_SPLIT: begin
        ctl.shift = 1'b1;
        if (at_big) begin
          tail = split_final ? {who, k} : {OWNER_BITS'(0), split_order};
        end else if (carrying) begin
          tail = carry;
        end
      end
      S_QUERY: begin
        ctl.shift = adv;
      end
      default: begin
        ctl.shift = 1'b0;
      end
    endcase
    ctl.load   = rst || cfg_xfer;
    load_entry = {OWNER_BITS'(0), rst ? RESET_ORDER : cfg_order};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      total       <= TW'(1);
      found_exact <= 1'b0;
      found_big   <= 1'b0;
      carrying    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        total <= TW'(1);
      end
      if (ctl.shift) begin
        pos <= pass_end ? '0 : pos + 1'b1;
      end
      if (in_xfer) begin
        who         <= OWNER_BITS'(in_owner);
        size        <= in_size;
        pw          <= 32'd1;
        k           <= '0;
        found_exact <= 1'b0;
        found_big   <= 1'b0;
      end
      if ((state == S_ORDER) && order_more) begin
        pw <= pw << 1;
        k  <= k + 1'b1;
      end
      if (state == S_SCAN) begin
        if (hit_exact) begin
          found_exact <= 1'b1;
        end
        if (hit_big) begin
          found_big <= 1'b1;
          big_pos   <= pos;
          big_order <= h_order;
        end
        if (pass_end) begin
          if (exact_any) begin
            res_status <= STAT_ALLOC;
          end else if (!big_any) begin
            res_status <= STAT_NOFIT;
          end else begin
            res_status <= STAT_FULL;
          end
        end
      end
      if (state == S_SPLIT) begin
        // insert the upper half right after the split block; the rest slides up
        if (at_big) begin
          carry    <= {OWNER_BITS'(0), split_order};
          carrying <= 1'b1;
        end else if (carrying) begin
          carry <= head;
        end
        if (pass_end) begin
          carrying   <= 1'b0;
          total      <= total + 1'b1;
          big_order  <= split_order;
          res_status <= split_final ? STAT_ALLOC : STAT_FULL;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_count <= COUNT_W'(total);
      if (state == S_REPLY) begin
        out_status <= res_status;
        out_owner  <= '0;
        out_last   <= 1'b1;
      end else begin
        out_status <= STAT_ENTRY;
        out_owner  <= ID_W'(h_owner);
        out_last   <= TW'(pos_ext + 1'b1) == total;
      end
    end
  end

endmodule

// File: src/bsa_checker.sv
// Port-level checks for the buddy split allocator, bound to the top level.
module bsa_checker
  import bsa_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]            m_tuser,
  input logic                  m_tlast,
  input logic                  cfg_valid,
  input logic                  cfg_ready
);

  // result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one request at a time: no new request in the cycle after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken back to back");

  // a listing in progress keeps the request side closed
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == STAT_ENTRY) && !m_tlast) |-> !s_tready)
    else $error("request taken during listing");

  // register writes and requests never complete together
  a_cfg_excl: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> !(s_tvalid && s_tready))
    else $error("config write and request in same cycle");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind buddy_split_allocator_top bsa_checker u_bsa_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// File: dv/bsa_req_pkg.sv
// Request encodings shared by the allocator testbench files.
`timescale 1ns / 1ps
package bsa_req_pkg;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

// File: dv/bsa_list_checker.sv
// Checker for the buddy split allocator: tracks the block list and compares every result.
`timescale 1ns / 1ps
module bsa_list_checker
  import bsa_pkg::*, bsa_req_pkg::*;
#(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // owner[15:0], request_size[46:16], zero[47]
  input  logic                  s_tuser,   // func
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // block_count[6:0], entry_owner[22:7], zero[23]
  input  logic [1:0]            m_tuser,   // status
  input  logic                  m_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [ORDER_W-1:0]    cfg_data,
  output int                    fault_count,
  output int                    reports_waiting,
  output int                    granted,
  output int                    no_fit,
  output int                    list_full,
  output int                    entries_listed
);

  typedef struct packed {
    alloc_status_t      status;
    logic [COUNT_W-1:0] count;
    logic [ID_W-1:0]    owner;
    logic               last;
  } block_report_t;

  logic [ID_W-1:0]    blk_owner [MAX_BLOCKS];
  logic [ORDER_W-1:0] blk_order [MAX_BLOCKS];
  int                 blk_total;
  logic [ORDER_W-1:0] space_order;
  block_report_t      reports_due [$];

  function automatic void list_rebuild();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      blk_owner[i] = '0;
      blk_order[i] = '0;
    end
    blk_order[0] = space_order;
    blk_total    = 1;
  endfunction

  // Smallest k with 2**k >= size; zero counts as one.
  function automatic int order_for_size(logic [SIZE_W-1:0] size);
    int k;
    k = 0;
    while (k < 40 && (64'd1 << k) < {33'd0, size}) k++;
    return k;
  endfunction

  function automatic alloc_status_t allocate_block(logic [ID_W-1:0] who,
                                                   logic [SIZE_W-1:0] size);
    int k;
    int big;
    k = order_for_size(size);
    while (1) begin
      for (int j = 0; j < blk_total; j++) begin
        if (blk_owner[j] == '0 && int'(blk_order[j]) == k) begin
          blk_owner[j] = who;
          return STAT_ALLOC;
        end
      end
      big = -1;
      for (int j = 0; j < blk_total && big < 0; j++) begin
        if (blk_owner[j] == '0 && int'(blk_order[j]) > k) big = j;
      end
      if (big < 0) return STAT_NOFIT;
      if (blk_total + 1 > MAX_BLOCKS) return STAT_FULL;
      // halve in place: open a slot after big, splits stay even if we fail later
      for (int j = blk_total - 1; j > big; j--) begin
        blk_owner[j + 1] = blk_owner[j];
        blk_order[j + 1] = blk_order[j];
      end
      blk_order[big]     = blk_order[big] - 1'b1;
      blk_owner[big + 1] = '0;
      blk_order[big + 1] = blk_order[big];
      blk_total++;
    end
  endfunction

  function automatic void predict_request(logic func, logic [ID_W-1:0] who,
                                          logic [SIZE_W-1:0] size);
    block_report_t rep;
    if (func == FUNC_QUERY) begin
      for (int i = 0; i < blk_total; i++) begin
        rep.status = STAT_ENTRY;
        rep.count  = COUNT_W'(blk_total);
        rep.owner  = blk_owner[i];
        rep.last   = (i == blk_total - 1);
        reports_due.push_back(rep);
        entries_listed++;
      end
    end else begin
      rep.status = allocate_block(who, size);
      rep.count  = COUNT_W'(blk_total);
      rep.owner  = '0;
      rep.last   = 1'b1;
      reports_due.push_back(rep);
      case (rep.status)
        STAT_ALLOC: granted++;
        STAT_NOFIT: no_fit++;
        default:    list_full++;
      endcase
    end
  endfunction

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  function automatic void check_result();
    block_report_t want;
    if (reports_due.size() == 0) begin
      $error("unexpected result: status %0d, block_count %0d, entry_owner %0d, last %0d",
             m_tuser, m_tdata[COUNT_W-1:0], m_tdata[COUNT_W +: ID_W], m_tlast);
      fault_count++;
    end else begin
      want = reports_due.pop_front();
      field_check("status", 32'(want.status), 32'(m_tuser));
      field_check("block_count", 32'(want.count), 32'(m_tdata[COUNT_W-1:0]));
      field_check("entry_owner", 32'(want.owner), 32'(m_tdata[COUNT_W +: ID_W]));
      field_check("last", 32'(want.last), 32'(m_tlast));
    end
  endfunction

  // results are checked before new requests are predicted: a result can never
  // belong to a request taken on the same edge
  always @(posedge clk) begin
    if (rst) begin
      space_order = RESET_ORDER;
      list_rebuild();
      reports_due.delete();
      fault_count    = 0;
      granted        = 0;
      no_fit         = 0;
      list_full      = 0;
      entries_listed = 0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (cfg_valid && cfg_ready) begin
        space_order = cfg_data;
        list_rebuild();
      end
      if (s_tvalid && s_tready)
        predict_request(s_tuser, s_tdata[ID_W-1:0], s_tdata[ID_W +: SIZE_W]);
    end
    reports_waiting = reports_due.size();
  end

endmodule

// File: dv/buddy_split_allocator_top_test.sv
// Testbench top: request and register stimulus for the buddy split allocator, plus verdict.
`timescale 1ns / 1ps
module buddy_split_allocator_top_test;
  import bsa_pkg::*;
  import bsa_req_pkg::*;

  localparam int MAX_BLOCKS      = 64;
  localparam int ITEMS_PER_PHASE = 120;
  // A few ring passes: long enough for any stray result to show up after the drain.
  localparam int DRAIN_CYCLES    = 4 * MAX_BLOCKS;

  // Pacing per phase: none, sender gaps, receiver stalls, both.
  int idle_pct_tbl    [4] = '{0, 55, 0, 35};
  int stall_pct_tbl   [4] = '{0, 0, 55, 35};
  // Each phase opens on a fixed space size so both extremes are always hit.
  int first_space_tbl [4] = '{0, 30, 1, 29};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;    // owner[15:0], request_size[46:16], zero[47]
  logic                  s_tuser = 1'b0;  // func
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // block_count[6:0], entry_owner[22:7], zero[23]
  logic [1:0]            m_tuser;         // status
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [ORDER_W-1:0]    cfg_data = '0;   // total_order

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int requests_sent      = 0;
  int queries_sent       = 0;
  int rebuilds           = 0;

  int fault_count;
  int reports_waiting;
  int granted;
  int no_fit;
  int list_full;
  int entries_listed;

  buddy_split_allocator_top #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .OWNER_BITS (16)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bsa_list_checker #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fault_count     (fault_count),
    .reports_waiting (reports_waiting),
    .granted         (granted),
    .no_fit          (no_fit),
    .list_full       (list_full),
    .entries_listed  (entries_listed)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: stall decided fresh every cycle at the falling edge.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // One request transfer. Entered and left at a falling edge; tvalid is left
  // high so back-to-back requests never drop it within a time step.
  task automatic send_request(input logic func, input logic [ID_W-1:0] who,
                              input logic [SIZE_W-1:0] size);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {1'b0, size, who};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
    if (func == FUNC_QUERY) queries_sent++;
  endtask

  // Register write, only once every expected result is back and the block is idle.
  // Every request yields at least one result, so an empty queue means none is outstanding.
  task automatic write_space_order(input logic [ORDER_W-1:0] value);
    s_tvalid <= 1'b0;
    while (reports_waiting != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    rebuilds++;
  endtask

  function automatic logic [ID_W-1:0] pick_owner();
    if ($urandom_range(99) < 5) return '0;   // owner zero keeps the block free
    return ID_W'($urandom_range(16'hFFFF, 1));
  endfunction

  // Mostly sizes in one power-of-two band up to just past the space; some
  // zero and some fully random 31-bit sizes.
  function automatic logic [SIZE_W-1:0] pick_size(input int space);
    int          roll;
    int          k;
    int unsigned half;
    roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 12) return SIZE_W'($urandom);
    k = $urandom_range((space < 30) ? space + 1 : 30, 0);
    if (k == 0) return SIZE_W'(1);
    half = 32'd1 << (k - 1);
    return SIZE_W'(half + 1 + $urandom_range(half - 1, 0));
  endfunction

  // Fill runs pile up allocations of one or two units on a mid-size space until the list
  // runs out of entries; mixed runs spread sizes and queries over any space.
  task automatic run_segment(input int space, input int count, input bit fill);
    for (int i = 0; i < count; i++) begin
      if (fill) begin
        if (i % 16 == 15)
          send_request(FUNC_QUERY, ID_W'($urandom), SIZE_W'($urandom));
        else
          send_request(FUNC_ALLOC, pick_owner(),
                       ($urandom_range(3) == 0) ? SIZE_W'(2) : SIZE_W'(1));
      end else if ($urandom_range(99) < 20) begin
        send_request(FUNC_QUERY, ID_W'($urandom), SIZE_W'($urandom));
      end else begin
        send_request(FUNC_ALLOC, pick_owner(), pick_size(space));
      end
    end
  endtask

  initial begin
    int space;
    int seg;
    int done;
    int count;
    bit fill;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: no register write yet, so the first items see the reset space (order 6).
    send_request(FUNC_QUERY, 16'h0000, 31'd0);           // single free block after reset
    send_request(FUNC_ALLOC, 16'hFFFF, 31'd1);           // six splits down to one unit
    send_request(FUNC_ALLOC, 16'h0001, 31'd0);           // size zero acts as size one
    send_request(FUNC_ALLOC, 16'h0000, 31'd2);           // owner zero: granted, stays free
    send_request(FUNC_ALLOC, 16'h5A5A, 31'd2);           // same block handed out again
    send_request(FUNC_ALLOC, 16'h1234, 31'd64);          // whole space no longer free
    send_request(FUNC_ALLOC, 16'h4321, 31'h4000_0000);   // far above the space
    send_request(FUNC_ALLOC, 16'h7FFF, 31'h7FFF_FFFF);   // largest size field
    send_request(FUNC_QUERY, 16'hFFFF, 31'h7FFF_FFFF);

    write_space_order(5'd30);
    send_request(FUNC_ALLOC, 16'h8000, 31'h4000_0000);   // exact fit of the largest space
    send_request(FUNC_ALLOC, 16'h0002, 31'd1);           // nothing free left
    send_request(FUNC_QUERY, 16'h0000, 31'd0);

    write_space_order(5'd30);
    send_request(FUNC_ALLOC, 16'h00FF, 31'h7FFF_FFFF);   // order 31, above the order-30 space
    send_request(FUNC_ALLOC, 16'hFF00, 31'd1);           // thirty splits in one request
    send_request(FUNC_ALLOC, 16'h3C3C, 31'h2000_0000);
    send_request(FUNC_QUERY, 16'h0000, 31'd0);

    write_space_order(5'd0);
    send_request(FUNC_ALLOC, 16'hAAAA, 31'd1);
    send_request(FUNC_ALLOC, 16'h5555, 31'd1);           // single unit already taken
    send_request(FUNC_ALLOC, 16'h0F0F, 31'd0);
    send_request(FUNC_QUERY, 16'h0000, 31'd0);

    // Random phases; the list-full case comes out of the fill runs.
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = idle_pct_tbl[phase];
      receiver_stall_pct = stall_pct_tbl[phase];
      done = 0;
      seg  = 0;
      while (done < ITEMS_PER_PHASE) begin
        fill = (seg != 0) && ($urandom_range(99) < 35);
        if (seg == 0)
          space = first_space_tbl[phase];
        else if (fill)
          space = $urandom_range(11, 7);
        else if ($urandom_range(1) == 1)
          space = $urandom_range(12, 0);
        else
          space = $urandom_range(30, 0);
        count = fill ? 72 : $urandom_range(40, 20);
        // keep each phase at its item budget
        if (count > ITEMS_PER_PHASE - done) count = ITEMS_PER_PHASE - done;
        write_space_order(space[ORDER_W-1:0]);
        run_segment(space, count, fill);
        done += count;
        seg++;
      end
    end

    s_tvalid <= 1'b0;
    while (reports_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d requests (%0d list queries) over %0d list rebuilds in four pacing mixes.",
             requests_sent, queries_sent, rebuilds);
    $display("Outcomes: %0d granted, %0d no fit, %0d list full, %0d listed entries.",
             granted, no_fit, list_full, entries_listed);
    if (fault_count == 0 && reports_waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run (split chains, full queries,
  // heavy stalls on both sides).
  initial begin
    #10_000_000;
    $display("Watchdog expired with %0d results outstanding", reports_waiting);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
